/* hdl/tbpc_pkg.sv */
// ----------------------------------------------------------------------------
// tbpc_pkg
// Shared types and constants of the two-button press classifier.
// ----------------------------------------------------------------------------
package tbpc_pkg;

    localparam int COUNT_WIDTH = 8;
    localparam int CFG_WIDTH   = 8;
    localparam int CFG_IDX_W   = 2;
    // compare width wide enough for both the hold counter and a threshold
    localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    localparam logic [CFG_WIDTH-1:0] SHORT_RESET = CFG_WIDTH'(3);
    localparam logic [CFG_WIDTH-1:0] LONG_RESET  = CFG_WIDTH'(100);

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS  = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    typedef struct packed {
        logic clock_up;
        logic clock_down;
        logic select_next;
        logic select_prev;
        logic select_mode;
        logic mode_toggled;
    } t_result;

endpackage

/* hdl/two_button_press_classifier_core.sv */
// ----------------------------------------------------------------------------
// two_button_press_classifier_core
// Short/long press classifier for two buttons with a two-state mode flag.
//
//   channel   handshake                 payload
//   input     i_valid / o_stall         i_first_down, i_second_down
//   result    o_valid / i_stall         o_clock_up .. o_mode_toggled
//   config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle while the result side does not stall; an item passes the
// input register, then counter update and routing into the result register.
// Synchronous active-low reset clears counters and mode and loads the default
// thresholds (short 3, long 100).
// A stalled result holds; the input register keeps filling until it too is
// full, and only then is o_stall raised.
// ----------------------------------------------------------------------------
module two_button_press_classifier_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_first_down,
    input  logic                             i_second_down,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_clock_up,
    output logic                             o_clock_down,
    output logic                             o_select_next,
    output logic                             o_select_prev,
    output logic                             o_select_mode,
    output logic                             o_mode_toggled,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tbpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tbpc_pkg::CFG_WIDTH-1:0]   i_cfg_data
);
    import tbpc_pkg::*;

    logic [CFG_WIDTH-1:0] r_short_ticks;
    logic [CFG_WIDTH-1:0] r_long_ticks;

    logic    r_in_valid;
    logic    r_first;
    logic    r_second;
    logic    r_out_valid;
    t_result r_out;

    logic    out_free;
    logic    in_free;
    logic    advance;
    t_event  first_ev;
    t_event  second_ev;
    t_result n_out;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign in_free  = !r_in_valid || out_free;
    assign o_stall  = !in_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_ticks <= SHORT_RESET;
            r_long_ticks  <= LONG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SHORT_TICKS: r_short_ticks <= i_cfg_data;
                REG_LONG_TICKS:  r_long_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_first  <= i_first_down;
            r_second <= i_second_down;
        end
    end

    tbpc_hold u_first_hold (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_down        (r_first),
        .i_short_ticks (r_short_ticks),
        .i_long_ticks  (r_long_ticks),
        .o_event       (first_ev)
    );

    tbpc_hold u_second_hold (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_down        (r_second),
        .i_short_ticks (r_short_ticks),
        .i_long_ticks  (r_long_ticks),
        .o_event       (second_ev)
    );

    tbpc_route u_route (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_first_ev  (first_ev),
        .i_second_ev (second_ev),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_clock_up     = r_out.clock_up;
    assign o_clock_down   = r_out.clock_down;
    assign o_select_next  = r_out.select_next;
    assign o_select_prev  = r_out.select_prev;
    assign o_select_mode  = r_out.select_mode;
    assign o_mode_toggled = r_out.mode_toggled;

    // a toggle tick carries no short-press pulse
    a_toggle_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_mode_toggled) |->
        !(o_clock_up || o_clock_down || o_select_next || o_select_prev))
        else $error("short pulse on a mode toggle item");

    // pulses follow the mode when no toggle happened
    a_route_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_mode_toggled) |->
        (o_select_mode ? !(o_clock_up || o_clock_down)
                       : !(o_select_next || o_select_prev)))
        else $error("short press routed to the wrong mode");

    // a waiting input item is not lost while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_first)
        && $stable(r_second)))
        else $error("input register changed while stalled");

endmodule

/* hdl/tbpc_hold.sv */
// ----------------------------------------------------------------------------
// tbpc_hold
// Saturating hold counter of one button and its short/long press decision.
// ----------------------------------------------------------------------------
module tbpc_hold (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_advance,
    input  logic                             i_down,
    input  logic [tbpc_pkg::CFG_WIDTH-1:0]   i_short_ticks,
    input  logic [tbpc_pkg::CFG_WIDTH-1:0]   i_long_ticks,
    output tbpc_pkg::t_event                 o_event
);
    import tbpc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic [CFG_WIDTH-1:0]   thr_short;
    logic [CMP_W-1:0]       old_x;
    logic [CMP_W-1:0]       next_x;
    logic                   at_max;

    // a zero short threshold behaves as one
    assign thr_short = (i_short_ticks == '0) ? CFG_WIDTH'(1) : i_short_ticks;
    assign at_max    = (r_cnt == CNT_MAX);
    assign old_x     = CMP_W'(r_cnt);

    always_comb begin
        if (i_down) begin
            n_cnt = at_max ? r_cnt : r_cnt + COUNT_WIDTH'(1);
        end else begin
            n_cnt = '0;
        end
    end

    assign next_x = CMP_W'(n_cnt);

    always_comb begin
        o_event = EV_NONE;
        if (i_down) begin
            // fires only on the step onto the threshold, never when stuck
            if (!at_max && next_x == CMP_W'(i_long_ticks)) begin
                o_event = EV_LONG;
            end
        end else if (old_x >= CMP_W'(thr_short) && old_x < CMP_W'(i_long_ticks)) begin
            o_event = EV_SHORT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_advance) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

/* hdl/tbpc_route.sv */
// ----------------------------------------------------------------------------
// tbpc_route
// Mode flag and routing of short presses to the pulse outputs.
// ----------------------------------------------------------------------------
module tbpc_route (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  tbpc_pkg::t_event   i_first_ev,
    input  tbpc_pkg::t_event   i_second_ev,
    output tbpc_pkg::t_result  o_result
);
    import tbpc_pkg::*;

    logic r_mode;
    logic n_mode;
    logic toggle;
    logic first_short;
    logic second_short;

    assign toggle       = (i_first_ev == EV_LONG) || (i_second_ev == EV_LONG);
    assign first_short  = (i_first_ev == EV_SHORT);
    assign second_short = (i_second_ev == EV_SHORT);
    assign n_mode       = r_mode ^ toggle;

    always_comb begin
        o_result              = '0;
        o_result.select_mode  = n_mode;
        o_result.mode_toggled = toggle;
        // toggle tick drops both short events
        if (!toggle) begin
            if (!r_mode) begin
                o_result.clock_up   = first_short;
                o_result.clock_down = second_short;
            end else begin
                o_result.select_next = first_short;
                o_result.select_prev = second_short;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_advance) begin
            r_mode <= n_mode;
        end
    end

endmodule

/* bench/two_button_press_classifier_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_button_press_classifier_core_tb
// Self-checking bench for the two-button short/long press classifier.
// A table of directed ticks runs first, then randomised press gestures over
// several threshold settings. Every accepted tick is fed to an in-bench
// model of the hold counters and mode flag; each result item is compared
// field by field against the oldest predicted one. Both handshakes idle at
// random, with one long result hold-off that backs the block up.
// ----------------------------------------------------------------------------
module two_button_press_classifier_core_tb;
    import tbpc_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_first_down = 1'b0;
    logic i_second_down = 1'b0;
    logic i_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_SHORT_TICKS;
    logic [CFG_WIDTH-1:0] i_cfg_data = '0;
    logic o_stall, o_valid, o_cfg_ready;
    logic o_clock_up, o_clock_down, o_select_next, o_select_prev;
    logic o_select_mode, o_mode_toggled;

    two_button_press_classifier_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_first_down  (i_first_down),
        .i_second_down (i_second_down),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_clock_up    (o_clock_up),
        .o_clock_down  (o_clock_down),
        .o_select_next (o_select_next),
        .o_select_prev (o_select_prev),
        .o_select_mode (o_select_mode),
        .o_mode_toggled(o_mode_toggled),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---- press model ----
    logic [COUNT_WIDTH-1:0] hold_first = '0;
    logic [COUNT_WIDTH-1:0] hold_second = '0;
    logic                   mode_select = 1'b0;
    logic [CFG_WIDTH-1:0]   thr_short = SHORT_RESET;
    logic [CFG_WIDTH-1:0]   thr_long = LONG_RESET;

    t_result pending_results[$];
    int      items_sent = 0;
    int      fails = 0;

    function automatic t_event press_event(input logic [COUNT_WIDTH-1:0] held,
                                           input logic down);
        longint unsigned old_c, nxt, lim, sh;
        old_c = held;
        lim   = thr_long;
        sh    = (thr_short == 0) ? 1 : thr_short;
        if (down) begin
            nxt = (held == '1) ? old_c : old_c + 1;
            return (nxt != old_c && nxt == lim) ? EV_LONG : EV_NONE;
        end
        return (old_c >= sh && old_c < lim) ? EV_SHORT : EV_NONE;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] hold_next(input logic [COUNT_WIDTH-1:0] held,
                                                         input logic down);
        if (!down)
            return '0;
        return (held == '1) ? held : held + 1'b1;
    endfunction

    function automatic t_result classify_tick(input logic f, input logic s);
        t_event  ev_f, ev_s;
        t_result r;
        ev_f = press_event(hold_first, f);
        ev_s = press_event(hold_second, s);
        hold_first  = hold_next(hold_first, f);
        hold_second = hold_next(hold_second, s);
        r = '0;
        if (ev_f == EV_LONG || ev_s == EV_LONG) begin
            // long press wins; shorts of this tick are dropped
            mode_select    = ~mode_select;
            r.mode_toggled = 1'b1;
        end else if (!mode_select) begin
            r.clock_up   = (ev_f == EV_SHORT);
            r.clock_down = (ev_s == EV_SHORT);
        end else begin
            r.select_next = (ev_f == EV_SHORT);
            r.select_prev = (ev_s == EV_SHORT);
        end
        r.select_mode = mode_select;
        return r;
    endfunction

    // ---- driving ----
    task automatic send_item(input logic f, input logic s, input bit typed,
                             input t_result want);
        t_result r;
        if (!(items_sent >= 250 && items_sent < 400)) begin
            while ($urandom_range(99) < 17) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid       <= 1'b1;
        i_first_down  <= f;
        i_second_down <= s;
        do @(posedge i_clk); while (o_stall);
        r = classify_tick(f, s);
        pending_results.push_back(typed ? want : r);
        items_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_SHORT_TICKS)
            thr_short = val;
        else if (idx == REG_LONG_TICKS)
            thr_long = val;
    endtask

    // ---- directed table ----
    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_WIDTH-1:0] val;
        logic                 f;
        logic                 s;
        int                   reps;
        bit                   typed;
        t_result              want;
    } t_step;

    t_step steps[$];

    function automatic void step_tick(input logic f, input logic s, input int reps = 1,
                                      input bit typed = 1'b0, input t_result want = '0);
        t_step st;
        st = '{is_write: 1'b0, idx: REG_SHORT_TICKS, val: '0, f: f, s: s, reps: reps,
               typed: typed, want: want};
        steps.push_back(st);
    endfunction

    function automatic void step_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_WIDTH-1:0] val);
        t_step st;
        st = '{is_write: 1'b1, idx: idx, val: val, f: 1'b0, s: 1'b0, reps: 0,
               typed: 1'b0, want: '0};
        steps.push_back(st);
    endfunction

    // ---- random gestures ----
    function automatic int pick_hold();
        int sh, v;
        sh = (thr_short == 0) ? 1 : int'(thr_short);
        case ($urandom_range(5))
            0: v = sh - 1;
            1: v = sh;
            2: v = int'(thr_long) - 1;
            3: v = int'(thr_long);
            4: v = int'(thr_long) + 1;   // past the threshold, saturates at 255
            default: v = $urandom_range(1, 12);
        endcase
        if (v < 1)
            v = 1;
        if (v > 300)
            v = 300;
        return v;
    endfunction

    task automatic run_gesture();
        int kind, la, lb, off, span;
        kind = $urandom_range(9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 6))
                send_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
        end else begin
            la  = pick_hold();
            lb  = pick_hold();
            off = 0;
            if (kind <= 3)
                lb = 0;
            else if (kind <= 6)
                la = 0;
            else if (kind == 7)
                lb = la;
            else
                off = $urandom_range(0, la);
            span = (la > off + lb) ? la : off + lb;
            for (int t = 0; t < span; t++)
                send_item(t < la, (t >= off) && (t < off + lb), 1'b0, '0);
            send_item(1'b0, 1'b0, 1'b0, '0);
        end
    endtask

    // ---- result side: stalls, with one long hold-off ----
    initial begin : result_stall
        bit holdoff_done;
        int calm_left;
        holdoff_done = 1'b0;
        calm_left    = 0;
        forever begin
            @(posedge i_clk);
            // start the hold-off only while the sender is offering items
            if (!holdoff_done && items_sent >= 120 && i_valid) begin
                i_stall <= 1'b1;
                repeat (48) @(posedge i_clk);
                holdoff_done = 1'b1;
                calm_left    = 200;
            end else if (calm_left > 0) begin
                calm_left--;
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 17);
            end
        end
    end

    task automatic check_bit(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected");
                fails++;
            end else begin
                want = pending_results.pop_front();
                check_bit("clock_up", want.clock_up, o_clock_up);
                check_bit("clock_down", want.clock_down, o_clock_down);
                check_bit("select_next", want.select_next, o_select_next);
                check_bit("select_prev", want.select_prev, o_select_prev);
                check_bit("select_mode", want.select_mode, o_select_mode);
                check_bit("mode_toggled", want.mode_toggled, o_mode_toggled);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[two_button_press_classifier_core] ERROR");
        $finish;
    end

    // ---- main sequence ----
    initial begin : stimulus
        int sh_set[9];
        int lg_set[9];
        int budget[9];
        int start;

        sh_set = '{3, 1, 0, 5, 255, 5, 2, 0, 0};
        lg_set = '{100, 2, 1, 255, 0, 3, 9, 0, 0};
        budget = '{30, 25, 25, 1, 1, 25, 25, 25, 1};

        // defaults: short 3, long 100; bits are up,down,next,prev,mode,toggled
        step_tick(1'b0, 1'b0, 1, 1'b1, 6'b000000);
        step_tick(1'b1, 1'b1, 3);
        step_tick(1'b0, 1'b0, 1, 1'b1, 6'b110000);   // both short, clock adjust
        step_tick(1'b1, 1'b0);
        step_tick(1'b0, 1'b0, 1, 1'b1, 6'b000000);   // released too early
        // short threshold zero acts as one
        step_write(REG_SHORT_TICKS, 8'd0);
        step_write(REG_LONG_TICKS, 8'd2);
        step_tick(1'b1, 1'b0);
        step_tick(1'b0, 1'b0);
        step_tick(1'b0, 1'b1);
        step_tick(1'b0, 1'b1, 1, 1'b1, 6'b000011);   // long press, into select
        step_tick(1'b1, 1'b1);
        step_tick(1'b0, 1'b1);
        step_tick(1'b0, 1'b0);
        // both long on one tick: single toggle
        step_tick(1'b1, 1'b1);
        step_tick(1'b1, 1'b1, 1, 1'b1, 6'b000001);
        step_tick(1'b0, 1'b0);
        // short dropped on toggle tick
        step_tick(1'b1, 1'b1);
        step_tick(1'b0, 1'b1, 1, 1'b1, 6'b000011);
        step_tick(1'b0, 1'b0);
        // unused indices, then long not above short
        step_write(CFG_IDX_W'(2), 8'hff);
        step_write(CFG_IDX_W'(3), 8'h00);
        step_write(REG_SHORT_TICKS, 8'd4);
        step_write(REG_LONG_TICKS, 8'd4);
        step_tick(1'b1, 1'b0, 4);
        step_tick(1'b0, 1'b0);
        // long threshold zero
        step_write(REG_LONG_TICKS, 8'd0);
        step_write(REG_SHORT_TICKS, 8'd1);
        step_tick(1'b1, 1'b1, 2);
        step_tick(1'b0, 1'b0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[k]) begin
            if (steps[k].is_write)
                write_reg(steps[k].idx, steps[k].val);
            else
                repeat (steps[k].reps)
                    send_item(steps[k].f, steps[k].s, steps[k].typed, steps[k].want);
        end

        sh_set[7] = $urandom_range(1, 20);
        lg_set[7] = sh_set[7] + $urandom_range(1, 30);
        sh_set[8] = $urandom_range(0, 255);
        lg_set[8] = $urandom_range(0, 40);
        for (int p = 0; p < 9; p++) begin
            write_reg(REG_SHORT_TICKS, CFG_WIDTH'(sh_set[p]));
            write_reg(REG_LONG_TICKS, CFG_WIDTH'(lg_set[p]));
            start = items_sent;
            while (items_sent - start < budget[p])
                run_gesture();
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (fails == 0 && pending_results.size() == 0)
            $display("[two_button_press_classifier_core] OK");
        else
            $display("[two_button_press_classifier_core] ERROR");
        $finish;
    end

endmodule
